/* rtl/core/odrgb_pkg.sv */
package odrgb_pkg;

   localparam int MAX_LINE_WIDTH = 4096;
   localparam int COL_W = $clog2(MAX_LINE_WIDTH);
   localparam int LW_W = 13;
   localparam int THR_W = 6;
   localparam int PIX_W = 24;
   localparam int RSP_W = 32;
   localparam int ADDR_W = 3;
   localparam logic [ADDR_W-3:0] REG_LINE_WIDTH = 1'b0;
   localparam logic [LW_W-1:0] LINE_WIDTH_RESET = 13'd640;
   localparam logic [LW_W-1:0] MAX_LW = LW_W'(MAX_LINE_WIDTH);

   typedef logic [THR_W-1:0] thr_type;

   function automatic thr_type bayer_thr(input logic [2:0] row, input logic [2:0] col);
      thr_type t;
      case ({row, col})
         6'd0:  t = 6'd0;   6'd1:  t = 6'd48;  6'd2:  t = 6'd12;  6'd3:  t = 6'd60;
         6'd4:  t = 6'd3;   6'd5:  t = 6'd51;  6'd6:  t = 6'd15;  6'd7:  t = 6'd63;
         6'd8:  t = 6'd32;  6'd9:  t = 6'd16;  6'd10: t = 6'd44;  6'd11: t = 6'd28;
         6'd12: t = 6'd35;  6'd13: t = 6'd19;  6'd14: t = 6'd47;  6'd15: t = 6'd31;
         6'd16: t = 6'd8;   6'd17: t = 6'd56;  6'd18: t = 6'd4;   6'd19: t = 6'd52;
         6'd20: t = 6'd11;  6'd21: t = 6'd59;  6'd22: t = 6'd7;   6'd23: t = 6'd55;
         6'd24: t = 6'd40;  6'd25: t = 6'd24;  6'd26: t = 6'd36;  6'd27: t = 6'd20;
         6'd28: t = 6'd43;  6'd29: t = 6'd27;  6'd30: t = 6'd39;  6'd31: t = 6'd23;
         6'd32: t = 6'd2;   6'd33: t = 6'd50;  6'd34: t = 6'd14;  6'd35: t = 6'd62;
         6'd36: t = 6'd1;   6'd37: t = 6'd49;  6'd38: t = 6'd13;  6'd39: t = 6'd61;
         6'd40: t = 6'd34;  6'd41: t = 6'd18;  6'd42: t = 6'd46;  6'd43: t = 6'd30;
         6'd44: t = 6'd33;  6'd45: t = 6'd17;  6'd46: t = 6'd45;  6'd47: t = 6'd29;
         6'd48: t = 6'd10;  6'd49: t = 6'd58;  6'd50: t = 6'd6;   6'd51: t = 6'd54;
         6'd52: t = 6'd9;   6'd53: t = 6'd57;  6'd54: t = 6'd5;   6'd55: t = 6'd53;
         6'd56: t = 6'd42;  6'd57: t = 6'd26;  6'd58: t = 6'd38;  6'd59: t = 6'd22;
         6'd60: t = 6'd41;  6'd61: t = 6'd25;  6'd62: t = 6'd37;  6'd63: t = 6'd21;
         default: t = '0;
      endcase
      return t;
   endfunction

   function automatic logic [7:0] add_sat(input logic [7:0] chan, input thr_type t);
      logic [8:0] s;
      s = {1'b0, chan} + {3'b000, t};
      return s[8] ? 8'hFF : s[7:0];
   endfunction

endpackage

/* rtl/core/ordered_dither_rgb332_top.sv */
// An accepted req word passes the stage 1 and stage 2 registers to become its rsp word.
// Throughput: one word per cycle while rsp_tready does not stall the output; stage 1
// registers pixel and Bayer threshold, stage 2 registers the saturated, quantized result.
// Reset (synchronous, active high): pipeline empty, column and row phase zero,
// line_width 640.
module ordered_dither_rgb332_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [odrgb_pkg::PIX_W-1:0]         req_tdata,   // pixel_rgb[23:0]
   input  logic                                req_tuser,   // frame_start
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [odrgb_pkg::RSP_W-1:0]         rsp_tdata,   // color_index[7:0], color_rgb[31:8]
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [odrgb_pkg::ADDR_W-1:0]        csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   logic [odrgb_pkg::LW_W-1:0]  line_width_ff;
   logic [odrgb_pkg::COL_W-1:0] col_ff, col_in, col_cur;
   logic [2:0]                  row_ff, row_in, row_cur;
   logic [odrgb_pkg::LW_W-1:0]  eff_width, col_next;
   logic                        wrap;

   logic                        s1_valid_ff, s1_valid_in;
   logic [odrgb_pkg::PIX_W-1:0] pix_ff;
   odrgb_pkg::thr_type          thr_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [odrgb_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic                        s2_adv, req_acc, cfg_wr;
   logic [7:0]                  r_sat, g_sat, b_sat;
   logic [2:0]                  ri, gi;
   logic [1:0]                  bi;

   // config
   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr[odrgb_pkg::ADDR_W-1:2] == odrgb_pkg::REG_LINE_WIDTH);
   assign csr_prdata = (csr_paddr[odrgb_pkg::ADDR_W-1:2] == odrgb_pkg::REG_LINE_WIDTH) ?
                       {{(32-odrgb_pkg::LW_W){1'b0}}, line_width_ff} : 32'd0;

   // handshake
   assign s2_adv     = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s2_adv;
   assign req_acc    = req_tvalid && req_tready;

   // position
   always_comb begin
      col_cur = req_tuser ? '0 : col_ff;
      row_cur = req_tuser ? '0 : row_ff;
      if (line_width_ff == '0) begin
         eff_width = odrgb_pkg::LW_W'(1);
      end else if (line_width_ff > odrgb_pkg::MAX_LW) begin
         eff_width = odrgb_pkg::MAX_LW;
      end else begin
         eff_width = line_width_ff;
      end
      col_next = {1'b0, col_cur} + odrgb_pkg::LW_W'(1);
      wrap = (col_next >= eff_width);
      col_in = col_ff;
      row_in = row_ff;
      if (req_acc) begin
         col_in = wrap ? '0 : col_next[odrgb_pkg::COL_W-1:0];
         row_in = wrap ? row_cur + 3'd1 : row_cur;
      end
   end

   // result
   always_comb begin
      r_sat = odrgb_pkg::add_sat(pix_ff[23:16], thr_ff);
      g_sat = odrgb_pkg::add_sat(pix_ff[15:8], thr_ff);
      b_sat = odrgb_pkg::add_sat(pix_ff[7:0], thr_ff);
      ri = r_sat[7:5];
      gi = g_sat[7:5];
      bi = b_sat[7:6];
      rsp_data_in = {ri, 5'b0, gi, 5'b0, bi, 6'b0, ri, gi, bi};
      s1_valid_in = req_acc ? 1'b1 : (s2_adv ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s2_adv ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= odrgb_pkg::LINE_WIDTH_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cfg_wr) begin
            line_width_ff <= csr_pwdata[odrgb_pkg::LW_W-1:0];
         end
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         pix_ff <= req_tdata;
         thr_ff <= odrgb_pkg::bayer_thr(row_cur, col_cur[2:0]);
      end
      if (s2_adv && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_frame_start_col: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> col_ff <= odrgb_pkg::COL_W'(1))
      else $error("column not restarted on frame start");
   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_adv |=> rsp_tvalid)
      else $error("stage 1 word lost");
   a_index_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:5] == rsp_tdata[31:29]) &&
                     (rsp_tdata[4:2] == rsp_tdata[23:21]) &&
                     (rsp_tdata[1:0] == rsp_tdata[15:14]))
      else $error("index and palette disagree");
`endif

endmodule
